// ===== sv/twcs_pkg.sv =====
`timescale 1ns / 1ps

package twcs_pkg;

   // screen and texture geometry
   localparam int SCREEN_HEIGHT = 512;
   localparam int CELL_SCALE    = 32;
   localparam int TEX_H_BITS    = 6;
   localparam int TEX_W_BITS    = 6;
   localparam int TEX_HEIGHT    = 1 << TEX_H_BITS;
   localparam int TEX_WIDTH     = 1 << TEX_W_BITS;
   localparam int TEX_COUNT     = 5;
   localparam int STORE_DEPTH   = TEX_COUNT * TEX_HEIGHT * TEX_WIDTH;

   // field widths
   localparam int ADDR_W   = 15;
   localparam int COLOR_W  = 24;
   localparam int COLUMN_W = 10;
   localparam int ROW_W    = 9;
   localparam int DIST_W   = 24;
   localparam int HIT_W    = 2;
   localparam int DIR_W    = 16;
   localparam int POS_W    = 24;
   localparam int REGION_W = 2;
   localparam int TEX_ID_W = 3;
   localparam int CSR_IDX_W = 1;

   // fixed point: position q.8, direction q.14, hit point q.22
   localparam int POS_FRAC = 8;
   localparam int DIR_FRAC = 14;
   localparam int ACC_FRAC = POS_FRAC + DIR_FRAC;

   // line height numerator, distance carries 8 fraction bits
   localparam int LH_NUM_VAL = SCREEN_HEIGHT * CELL_SCALE * 256;
   localparam int LH_W       = $clog2(LH_NUM_VAL + 1);

   // operation codes
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_RENDER = 1'b1;

   // hit kinds
   localparam logic [HIT_W-1:0] HIT_WALL = 2'd1;
   localparam logic [HIT_W-1:0] HIT_DOOR = 2'd2;

   // texture identifiers
   localparam logic [TEX_ID_W-1:0] TEX_NORTH = 3'd0;
   localparam logic [TEX_ID_W-1:0] TEX_SOUTH = 3'd1;
   localparam logic [TEX_ID_W-1:0] TEX_EAST  = 3'd2;
   localparam logic [TEX_ID_W-1:0] TEX_WEST  = 3'd3;
   localparam logic [TEX_ID_W-1:0] TEX_DOOR  = 3'd4;

   // result regions
   localparam logic [REGION_W-1:0] REGION_CEILING = 2'd0;
   localparam logic [REGION_W-1:0] REGION_WALL    = 2'd1;
   localparam logic [REGION_W-1:0] REGION_FLOOR   = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CEILING = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR   = 1'b1;

   typedef struct packed {
      logic                       op;
      logic [ADDR_W-1:0]          texel_addr;
      logic [COLOR_W-1:0]         texel_color;
      logic [COLUMN_W-1:0]        column;
      logic [ROW_W-1:0]           row;
      logic [DIST_W-1:0]          wall_distance;
      logic                       side;
      logic [HIT_W-1:0]           hit_kind;
      logic signed [DIR_W-1:0]    dir_x;
      logic signed [DIR_W-1:0]    dir_y;
      logic [POS_W-1:0]           pos_x;
      logic [POS_W-1:0]           pos_y;
   } req_type;

   typedef struct packed {
      logic [COLUMN_W-1:0]        pixel_column;
      logic [ROW_W-1:0]           pixel_row;
      logic [COLOR_W-1:0]         pixel_color;
      logic [REGION_W-1:0]        region;
   } rsp_type;

endpackage

// ===== sv/textured_wall_column_shader.sv =====
`timescale 1ns / 1ps
// Textured wall column shader: one pixel of a raycast wall column per request.
// Request channel (req_valid/req_ready/req_data): op 0 stores one texel in the
// five-texture store, op 1 shades one pixel. Only render requests give a
// result on the response channel (rsp_valid/rsp_ready/rsp_data), in request
// order. Ceiling and floor colours are written on the csr channel, which is
// always ready; write them only while no request is in flight.
// Throughput: one request per clock while the receiver takes results. The pipeline
// is made of the 23 one-bit stages of the line height divider, the 7 stages of the
// texture row divider, and the multiply, hit point, span, address, texture read and
// output stages around them.
// A texel write lands in the store in its pipeline slot, so any later render
// request sees it.
// Reset empties the pipeline and clears both colours; the texture store holds
// garbage until written. When the receiver stalls, the stalled result holds
// and requests keep entering until every stage behind it is full; empty
// stages close up, so nothing is lost or repeated.
module textured_wall_column_shader (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  twcs_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output twcs_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [twcs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [twcs_pkg::COLOR_W-1:0]   csr_data
);
   import twcs_pkg::*;

   // stage map
   localparam int TY_QW   = TEX_H_BITS + 1;
   localparam int P_IN    = 0;
   localparam int P_MUL   = 1;
   localparam int P_ADD   = 2;
   localparam int P_DIV1  = 3;
   localparam int P_SPAN  = P_DIV1 + LH_W;
   localparam int P_DIV2  = P_SPAN + 1;
   localparam int P_ADDR  = P_DIV2 + TY_QW;
   localparam int P_MEM   = P_ADDR + 1;
   localparam int P_OUT   = P_MEM + 1;
   localparam int N_STAGE = P_OUT + 1;

   localparam int ACC_W  = ACC_FRAC + TEX_W_BITS;
   localparam int PROD_W = DIST_W + 1 + DIR_W;
   localparam int NUM_W  = LH_W + TEX_H_BITS;
   localparam int SPAN_W = LH_W + 1;
   localparam logic [LH_W-1:0] LH_NUM = LH_W'(LH_NUM_VAL);
   localparam logic [SPAN_W-1:0] MID_ROW = SPAN_W'(SCREEN_HEIGHT / 2);
   localparam logic [SPAN_W-1:0] LAST_ROW = SPAN_W'(SCREEN_HEIGHT - 1);

   typedef struct packed {
      logic                    op;
      logic [ADDR_W-1:0]       addr;
      logic [COLOR_W-1:0]      texel;
      logic [COLUMN_W-1:0]     column;
      logic [ROW_W-1:0]        row;
      logic [DIST_W-1:0]       wall_dist;
      logic                    mirror;
      logic [TEX_ID_W-1:0]     tex;
      logic signed [DIR_W-1:0] dir;
      logic [POS_W-1:0]        pos;
      logic [ACC_W-1:0]        prod;
      logic [TEX_W_BITS-1:0]   tx;
      logic [DIST_W-1:0]       rem1;
      logic [LH_W-1:0]         lh;
      logic [REGION_W-1:0]     region;
      logic [NUM_W-1:0]        rem2;
      logic [TY_QW-1:0]        tyq;
   } item_type;

   item_type            item_ff [P_OUT];
   item_type            item_in [P_OUT];
   logic [N_STAGE-1:0]  valid_ff;
   logic [N_STAGE-1:0]  valid_in;
   logic [N_STAGE-1:0]  valid_up;
   logic [N_STAGE-1:0]  stage_en;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;
   logic [COLOR_W-1:0]  ceiling_ff;
   logic [COLOR_W-1:0]  floor_ff;
   logic [COLOR_W-1:0]  mem_rd_ff;
   logic [COLOR_W-1:0]  tex_mem [STORE_DEPTH];

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ceiling_ff <= '0;
         floor_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CEILING: ceiling_ff <= csr_data;
            CSR_FLOOR:   floor_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // a stage moves when the receiver takes or some stage at or after it is empty
   genvar k;
   generate
      for (k = 0; k < N_STAGE; k++) begin : g_en
         assign stage_en[k] = rsp_ready || !(&valid_ff[N_STAGE-1:k]);
      end
   endgenerate

   // valid bits, write requests leave after the store
   always_comb begin
      valid_up[P_IN] = req_valid;
      for (int i = 1; i < P_OUT; i++) begin
         valid_up[i] = valid_ff[i-1];
      end
      valid_up[P_OUT] = valid_ff[P_MEM] && (item_ff[P_MEM].op == OP_RENDER);
      valid_in = (valid_up & stage_en) | (valid_ff & ~stage_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = stage_en[P_IN];
   assign rsp_valid = valid_ff[P_OUT];
   assign rsp_data  = rsp_ff;

   // stage logic
   generate
      for (k = 0; k < P_OUT; k++) begin : g_stage
         if (k == P_IN) begin : g_in
            // distance floor, texture choice and mirror flag
            always_comb begin
               logic dx_pos;
               logic dx_neg;
               logic dy_pos;
               logic dy_neg;
               dx_pos = !req_data.dir_x[DIR_W-1] && (req_data.dir_x != '0);
               dx_neg = req_data.dir_x[DIR_W-1];
               dy_pos = !req_data.dir_y[DIR_W-1] && (req_data.dir_y != '0);
               dy_neg = req_data.dir_y[DIR_W-1];
               item_in[k]           = '0;
               item_in[k].op        = req_data.op;
               item_in[k].addr      = req_data.texel_addr;
               item_in[k].texel     = req_data.texel_color;
               item_in[k].column    = req_data.column;
               item_in[k].row       = req_data.row;
               item_in[k].wall_dist = (req_data.wall_distance == '0) ?
                                      DIST_W'(1) : req_data.wall_distance;
               item_in[k].dir    = req_data.side ? req_data.dir_x : req_data.dir_y;
               item_in[k].pos    = req_data.side ? req_data.pos_x : req_data.pos_y;
               item_in[k].mirror = (!req_data.side && dx_pos) ||
                                   (req_data.side && dy_neg);
               if (req_data.hit_kind == HIT_DOOR) begin
                  item_in[k].tex = TEX_DOOR;
               end else if (req_data.hit_kind == HIT_WALL && req_data.side && dy_pos) begin
                  item_in[k].tex = TEX_SOUTH;
               end else if (req_data.hit_kind == HIT_WALL && !req_data.side && dx_pos) begin
                  item_in[k].tex = TEX_EAST;
               end else if (req_data.hit_kind == HIT_WALL && !req_data.side && dx_neg) begin
                  item_in[k].tex = TEX_WEST;
               end else begin
                  item_in[k].tex = TEX_NORTH;
               end
            end
         end else if (k == P_MUL) begin : g_mul
            // distance times direction, only the low bits reach the texture column
            logic signed [PROD_W-1:0] prod_full;
            assign prod_full = $signed({1'b0, item_ff[k-1].wall_dist}) * item_ff[k-1].dir;
            always_comb begin
               item_in[k]      = item_ff[k-1];
               item_in[k].prod = prod_full[ACC_W-1:0];
            end
         end else if (k == P_ADD) begin : g_add
            // hit point, texture column taken from the integer bits
            logic [ACC_W-1:0] acc;
            assign acc = ACC_W'({item_ff[k-1].pos, {DIR_FRAC{1'b0}}}) + item_ff[k-1].prod;
            always_comb begin
               item_in[k]      = item_ff[k-1];
               item_in[k].tx   = item_ff[k-1].mirror ? ~acc[ACC_W-1 -: TEX_W_BITS] :
                                 acc[ACC_W-1 -: TEX_W_BITS];
               item_in[k].rem1 = '0;
               item_in[k].lh   = '0;
            end
         end else if (k < P_SPAN) begin : g_div1
            // line height divider, one quotient bit a stage
            localparam int B = LH_W - 1 - (k - P_DIV1);
            logic [DIST_W:0] part;
            logic [DIST_W:0] dsr;
            assign part = {item_ff[k-1].rem1, LH_NUM[B]};
            assign dsr  = {1'b0, item_ff[k-1].wall_dist};
            always_comb begin
               item_in[k] = item_ff[k-1];
               if (part >= dsr) begin
                  item_in[k].rem1  = DIST_W'(part - dsr);
                  item_in[k].lh[B] = 1'b1;
               end else begin
                  item_in[k].rem1  = part[DIST_W-1:0];
                  item_in[k].lh[B] = 1'b0;
               end
            end
         end else if (k == P_SPAN) begin : g_span
            // clamped span, region and texture row numerator
            logic [SPAN_W-1:0] half;
            logic [SPAN_W-1:0] row_x;
            logic [SPAN_W-1:0] start;
            logic [SPAN_W-1:0] stop;
            logic [NUM_W-1:0]  offs;
            assign half  = SPAN_W'(item_ff[k-1].lh >> 1);
            assign row_x = SPAN_W'(item_ff[k-1].row);
            assign start = (half >= MID_ROW) ? '0 : MID_ROW - half;
            assign stop  = (MID_ROW + half > LAST_ROW) ? LAST_ROW : MID_ROW + half;
            assign offs  = NUM_W'(row_x) + NUM_W'(half) - NUM_W'(MID_ROW);
            always_comb begin
               item_in[k] = item_ff[k-1];
               if (row_x < start) begin
                  item_in[k].region = REGION_CEILING;
               end else if (row_x > stop) begin
                  item_in[k].region = REGION_FLOOR;
               end else begin
                  item_in[k].region = REGION_WALL;
               end
               item_in[k].rem2 = NUM_W'(offs << TEX_H_BITS);
               item_in[k].tyq  = '0;
            end
         end else if (k < P_ADDR) begin : g_div2
            // texture row divider, quotient never above the texture height for a wall pixel
            localparam int B = TY_QW - 1 - (k - P_DIV2);
            logic [NUM_W-1:0] dsr;
            assign dsr = NUM_W'(NUM_W'(item_ff[k-1].lh) << B);
            always_comb begin
               item_in[k] = item_ff[k-1];
               if (item_ff[k-1].rem2 >= dsr) begin
                  item_in[k].rem2   = item_ff[k-1].rem2 - dsr;
                  item_in[k].tyq[B] = 1'b1;
               end else begin
                  item_in[k].tyq[B] = 1'b0;
               end
            end
         end else if (k == P_ADDR) begin : g_addr
            // store address for a render, row wraps at the texture height
            always_comb begin
               item_in[k] = item_ff[k-1];
               if (item_ff[k-1].op == OP_RENDER) begin
                  item_in[k].addr = ADDR_W'({item_ff[k-1].tex,
                                             item_ff[k-1].tyq[TEX_H_BITS-1:0],
                                             item_ff[k-1].tx});
               end
            end
         end else begin : g_mem
            always_comb begin
               item_in[k] = item_ff[k-1];
            end
         end

         always_ff @(posedge clock) begin
            if (stage_en[k]) begin
               item_ff[k] <= item_in[k];
            end
         end
      end
   endgenerate

   // texture store, one access a cycle in request order
   always_ff @(posedge clock) begin
      if (stage_en[P_MEM] && valid_ff[P_ADDR]) begin
         if (item_ff[P_ADDR].op == OP_WRITE) begin
            if (item_ff[P_ADDR].addr < ADDR_W'(STORE_DEPTH)) begin
               tex_mem[item_ff[P_ADDR].addr] <= item_ff[P_ADDR].texel;
            end
         end else begin
            mem_rd_ff <= tex_mem[item_ff[P_ADDR].addr];
         end
      end
   end

   // response register
   always_comb begin
      rsp_in.pixel_column = item_ff[P_MEM].column;
      rsp_in.pixel_row    = item_ff[P_MEM].row;
      rsp_in.region       = item_ff[P_MEM].region;
      case (item_ff[P_MEM].region)
         REGION_CEILING: rsp_in.pixel_color = ceiling_ff;
         REGION_FLOOR:   rsp_in.pixel_color = floor_ff;
         default:        rsp_in.pixel_color = mem_rd_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en[P_OUT]) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
